### hw/rtl/cfr_pkg.sv
`default_nettype none

package cfr_pkg;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HALF = 2'd1,
    PH_BODY = 2'd2
  } phase_e;

  localparam logic [7:0] HdrFirst  = 8'hA5;
  localparam logic [7:0] HdrSecond = 8'h5A;
  localparam logic [7:0] CrcPoly   = 8'h80;
  localparam logic [2:0] FrameLast = 3'd7;
  localparam logic [2:0] AngleLast = 3'd3;
  localparam logic [2:0] ForceLast = 3'd5;

  typedef struct packed {
    logic signed [15:0] angle_raw;
    logic signed [15:0] force_raw;
    logic [3:0]         device_error;
    logic [3:0]         device_status;
    logic               crc_ok;
  } result_t;

  // one byte through the reflected crc, eight shift steps
  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/cfr_in_stage.sv
`default_nettype none

module cfr_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] byte_i,
  input  wire logic       adv_i,
  output logic            valid_o,
  output logic [7:0]      byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  // the held byte leaves when the deframer takes it
  assign in_stall_o = valid_q && !adv_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

### hw/rtl/cfr_deframer.sv
`default_nettype none

module cfr_deframer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       fire_i,
  input  wire logic [7:0] byte_i,
  output logic            emit_o,
  output cfr_pkg::result_t result_o
);

  cfr_pkg::phase_e phase_q, phase_d;
  logic [2:0]      idx_q, idx_d;
  logic [7:0]      crc_q, crc_d;
  logic [15:0]     angle_q, angle_d;
  logic [15:0]     force_q, force_d;
  logic [7:0]      tag_q, tag_d;
  logic            crc_match;

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    crc_d   = crc_q;
    angle_d = angle_q;
    force_d = force_q;
    tag_d   = tag_q;
    unique case (phase_q)
      cfr_pkg::PH_HALF: begin
        if (byte_i == cfr_pkg::HdrSecond) begin
          crc_d   = cfr_pkg::crc_byte(crc_q, byte_i);
          phase_d = cfr_pkg::PH_BODY;
          idx_d   = 3'd2;
        end else if (byte_i == cfr_pkg::HdrFirst) begin
          // repeated first header byte keeps the partial match
          crc_d = cfr_pkg::crc_byte(8'h00, byte_i);
          idx_d = 3'd1;
        end else begin
          phase_d = cfr_pkg::PH_HUNT;
          idx_d   = 3'd0;
          crc_d   = 8'h00;
        end
      end
      cfr_pkg::PH_BODY: begin
        if (idx_q == cfr_pkg::FrameLast) begin
          phase_d = cfr_pkg::PH_HUNT;
          idx_d   = 3'd0;
          crc_d   = 8'h00;
        end else begin
          crc_d = cfr_pkg::crc_byte(crc_q, byte_i);
          if (idx_q <= cfr_pkg::AngleLast) begin
            angle_d = {angle_q[7:0], byte_i};
          end else if (idx_q <= cfr_pkg::ForceLast) begin
            force_d = {force_q[7:0], byte_i};
          end else begin
            tag_d = byte_i;
          end
          idx_d = idx_q + 3'd1;
        end
      end
      default: begin
        if (byte_i == cfr_pkg::HdrFirst) begin
          crc_d   = cfr_pkg::crc_byte(8'h00, byte_i);
          phase_d = cfr_pkg::PH_HALF;
          idx_d   = 3'd1;
        end else begin
          phase_d = cfr_pkg::PH_HUNT;
          idx_d   = 3'd0;
          crc_d   = 8'h00;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= cfr_pkg::PH_HUNT;
      idx_q   <= 3'd0;
      crc_q   <= 8'h00;
      angle_q <= 16'h0000;
      force_q <= 16'h0000;
      tag_q   <= 8'h00;
    end else if (fire_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      crc_q   <= crc_d;
      angle_q <= angle_d;
      force_q <= force_d;
      tag_q   <= tag_d;
    end
  end

  assign emit_o    = (phase_q == cfr_pkg::PH_BODY) && (idx_q == cfr_pkg::FrameLast);
  assign crc_match = (byte_i == crc_q);

  // all fields are zero on a crc mismatch
  always_comb begin
    result_o.angle_raw     = crc_match ? angle_q : 16'sd0;
    result_o.force_raw     = crc_match ? force_q : 16'sd0;
    result_o.device_error  = crc_match ? tag_q[7:4] : 4'h0;
    result_o.device_status = crc_match ? tag_q[3:0] : 4'h0;
    result_o.crc_ok        = crc_match;
  end

endmodule

`default_nettype wire

### hw/rtl/cfr_out_stage.sv
`default_nettype none

module cfr_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire cfr_pkg::result_t  result_i,
  output logic                   can_load_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output cfr_pkg::result_t       result_o
);

  logic             valid_q, valid_d;
  cfr_pkg::result_t result_q;

  assign can_load_o = !valid_q || !out_stall_i;
  assign valid_d    = load_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

### hw/rtl/crc8_frame_receiver.sv
`default_nettype none

// Byte-stream frame receiver: hunts for the header A5 5A, collects an 8-byte frame
// (big-endian signed angle and force words, a tag byte, a CRC-8 byte) and delivers one
// result per frame. One byte is accepted every cycle while in_stall_o is low; a result
// is presented once the frame's last byte has passed the input register, then the result
// register. out_stall_i reaches in_stall_o combinationally. A result that is still
// waiting holds the frame's CRC byte in the input register, which stalls the input until
// the result is taken; no other byte waits on the output side. On a CRC mismatch
// crc_ok_o is low and every other field is zero.
module crc8_frame_receiver (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         rx_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      angle_raw_o,
  output logic signed [15:0]      force_raw_o,
  output logic [3:0]              device_error_o,
  output logic [3:0]              device_status_o,
  output logic                    crc_ok_o
);

  logic             byte_valid;
  logic [7:0]       byte_q;
  logic             adv;
  logic             emit;
  logic             can_load;
  cfr_pkg::result_t frame_res;
  cfr_pkg::result_t out_res;

  // a byte that yields no result never waits on the output side
  assign adv = byte_valid && (!emit || can_load);

  cfr_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .byte_i     (rx_byte_i),
    .adv_i      (adv),
    .valid_o    (byte_valid),
    .byte_o     (byte_q)
  );

  cfr_deframer u_deframer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (adv),
    .byte_i   (byte_q),
    .emit_o   (emit),
    .result_o (frame_res)
  );

  cfr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv && emit),
    .result_i    (frame_res),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_res)
  );

  assign angle_raw_o     = out_res.angle_raw;
  assign force_raw_o     = out_res.force_raw;
  assign device_error_o  = out_res.device_error;
  assign device_status_o = out_res.device_status;
  assign crc_ok_o        = out_res.crc_ok;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !(adv && emit))
    else $error("waiting result overwritten");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && emit) |=> out_valid_o)
    else $error("finished frame not presented");

  a_bad_crc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !crc_ok_o) |-> (angle_raw_o == 16'sd0 && force_raw_o == 16'sd0
      && device_error_o == 4'h0 && device_status_o == 4'h0))
    else $error("fields not cleared on crc mismatch");
`endif

endmodule

`default_nettype wire
